>>> hw/rtl/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// shared types and constants for the integer to radix digits converter
// ----------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

  // dividend bits retired by the divider per cycle
  localparam int unsigned STEP_BITS = 8;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  // 'a' minus ten
  localparam logic [6:0] CHAR_ALPHA = 7'h57;
  localparam logic [3:0] DEC_DIGITS = 4'd10;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  radix;
    logic        is_signed;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last;
  } out_beat_t;

  // digit value to lower-case ascii
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + 7'(d);
    end else begin
      c = CHAR_ALPHA + 7'(d);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itrd_div_unit.sv
// ----------------------------------------------------------------------------
// itrd_div_unit
// iterative divider of a word by a small radix, STEP_BITS quotient bits a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_div_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WORD_BITS-1:0] dividend_i,
  input  wire logic [4:0]           radix_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [WORD_BITS-1:0]      quot_o,
  output logic [3:0]                rem_o
);
  import itrd_pkg::*;

  localparam int unsigned NCHUNK = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_W  = NCHUNK * STEP_BITS;
  localparam int unsigned CW     = $clog2(NCHUNK) + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [PAD_W-1:0] quot_q, quot_d;
  logic [3:0]       rem_q, rem_d;
  logic [PAD_W-1:0] step_quot;
  logic [3:0]       step_rem;
  logic             last_chunk;

  // restoring long division over one chunk
  always_comb begin
    logic [PAD_W-1:0] qw;
    logic [3:0]       rw;
    logic [4:0]       t;
    qw = quot_q;
    rw = rem_q;
    for (int k = 0; k < STEP_BITS; k++) begin
      t  = {rw, qw[PAD_W-1]};
      qw = {qw[PAD_W-2:0], 1'b0};
      if (t >= radix_i) begin
        rw    = 4'(t - radix_i);
        qw[0] = 1'b1;
      end else begin
        rw = t[3:0];
      end
    end
    step_quot = qw;
    step_rem  = rw;
  end

  assign last_chunk = (cnt_q == CW'(NCHUNK - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = PAD_W'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = step_quot;
      rem_d  = step_rem;
      cnt_d  = cnt_q + CW'(1);
      if (last_chunk) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q[WORD_BITS-1:0];
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/itrd_digit_stack.sv
// ----------------------------------------------------------------------------
// itrd_digit_stack
// shift-register lifo that reverses the digit order
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_digit_stack #(
  parameter int unsigned DEPTH = 33
) (
  input  wire logic       clk_i,
  input  wire logic       push_i,
  input  wire logic       pop_i,
  input  wire logic [3:0] digit_i,
  output logic [3:0]      top_o
);

  logic [3:0] ent_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[0] <= digit_i;
      for (int i = 1; i < DEPTH; i++) begin
        ent_q[i] <= ent_q[i-1];
      end
    end else if (pop_i) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
      ent_q[DEPTH-1] <= '0;
    end
  end

  assign top_o = ent_q[0];

endmodule

`default_nettype wire

>>> hw/rtl/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// one digit per pass of the single divider, least significant first; a minus
//   sign goes out ahead of the digits of a negative number
// a new number is accepted only in idle, after the last char of the previous
//   one is loaded; chars leave one per cycle while out_ready_i is high
// reset: async active low, returns to idle with no beat pending
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire itrd_pkg::in_beat_t   in_beat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output itrd_pkg::out_beat_t       out_beat_o
);
  import itrd_pkg::*;

  // at most WORD_BITS digits, reached in radix 2
  localparam int unsigned DEPTH = WORD_BITS;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic             out_valid_q;
  out_beat_t        out_beat_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [4:0]       radix_q;

  logic                 accept;
  logic [WORD_BITS-1:0] word;
  logic                 neg_in;
  logic [WORD_BITS-1:0] mag;
  logic [4:0]           radix_sat;
  logic                 div_start;
  logic [WORD_BITS-1:0] div_dividend;
  logic                 div_busy;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_quot;
  logic [3:0]           div_rem;
  logic                 div_more;
  logic                 push;
  logic                 pop;
  logic                 slot_free;
  logic                 out_load;
  logic [3:0]           stack_top;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // input word, truncated or zero extended to the configured width
  assign word   = WORD_BITS'(in_beat_i.value);
  assign neg_in = in_beat_i.is_signed && word[WORD_BITS-1];
  // magnitude mod 2^WORD_BITS, so the most negative word comes out right
  assign mag    = neg_in ? WORD_BITS'(~word + WORD_BITS'(1)) : word;

  always_comb begin
    radix_sat = in_beat_i.radix;
    if (in_beat_i.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_beat_i.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end
  end

  // digits come out least significant first; the loop stops on a zero quotient
  assign div_more     = (div_quot != '0);
  assign div_start    = accept || (state_q == ST_DIV && div_done && div_more);
  assign div_dividend = (state_q == ST_IDLE) ? mag : div_quot;

  itrd_div_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .radix_i    (radix_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // output register takes a new beat when empty or being drained
  assign slot_free = !out_valid_q || out_ready_i;
  assign out_load  = ((state_q == ST_SIGN) || (state_q == ST_EMIT)) && slot_free;
  assign push      = (state_q == ST_DIV) && div_done;
  assign pop       = (state_q == ST_EMIT) && slot_free;

  // stack pops the most significant digit first
  itrd_digit_stack #(
    .DEPTH (DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .push_i  (push),
    .pop_i   (pop),
    .digit_i (div_rem),
    .top_o   (stack_top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      radix_q     <= RADIX_MIN;
    end else begin
      // a new beat loads, otherwise a beat taken downstream clears
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            neg_q   <= neg_in;
            radix_q <= radix_sat;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cnt_q <= cnt_q + CNT_W'(1);
            if (!div_more) begin
              state_q <= neg_q ? ST_SIGN : ST_EMIT;
            end
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_beat_q.out_char <= CHAR_MINUS;
            out_beat_q.last     <= 1'b0;
            state_q             <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_beat_q.out_char <= digit_char(stack_top);
            out_beat_q.last     <= (cnt_q == CNT_W'(1));
            cnt_q               <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // no new number while the divider still works on the previous one
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("divider busy while idle");

  // digit count never exceeds the stack depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("digit count overflow");

  // emission always has a digit left on the stack
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0))
    else $error("emit with empty stack");

  // a divider result only shows up during the division phase
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider result outside division phase");

endmodule

`default_nettype wire
